/* rtl/core/isn_pkg.sv */
// Package for the interpolated sample-and-hold noise core.
// Holds widths, register indexes, sequencer states, handshake structs and
// the rounding and saturation helpers. Depends on nothing.
package isn_pkg;

  // Field and level widths.
  localparam int LEVEL_WIDTH = 24;
  localparam int COUNT_WIDTH = 32;
  localparam int RATE_W      = 18;
  localparam int AMP_W       = 24;
  localparam int PATTERN_W   = 21;
  localparam int FREQ_W      = 32;

  // Configuration port.
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam int REG_W  = 2;

  localparam logic [REG_W-1:0] REG_SAMPLE_RATE = 2'd0;
  localparam logic [REG_W-1:0] REG_AMPLITUDE   = 2'd1;
  localparam logic [REG_W-1:0] REG_OFFSET      = 2'd2;
  localparam logic [REG_W-1:0] REG_PATTERN     = 2'd3;

  localparam logic [RATE_W-1:0]    RESET_SAMPLE_RATE = RATE_W'(44100);
  localparam logic [AMP_W-1:0]     RESET_AMPLITUDE   = AMP_W'(65536);

  // Shared multiplier.
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  // Level arithmetic with headroom before saturation.
  localparam int SUM_W  = LEVEL_WIDTH + 4;
  localparam int DIFF_W = LEVEL_WIDTH + 1;

  // Fraction t and fade curve, Q0.16 with room for the value one.
  localparam int FRAC_W = 16;
  localparam int T_W    = FRAC_W + 1;
  localparam int S_W    = T_W + 3;
  localparam logic [T_W-1:0] ONE_Q16   = T_W'(1) << FRAC_W;
  localparam logic [S_W-1:0] FADE_GAIN = S_W'(5);

  // Shared divider.
  localparam int FREQ_FRAC_W = 12;
  localparam int DIV_NUM_W   = RATE_W + FREQ_FRAC_W;
  localparam int DIV_W       = 32;
  localparam int DIV_ITER_W  = $clog2(DIV_NUM_W + 1);
  localparam logic [DIV_ITER_W-1:0] PERIOD_ITERS = DIV_ITER_W'(DIV_NUM_W);
  localparam logic [DIV_ITER_W-1:0] FRAC_ITERS   = DIV_ITER_W'(FRAC_W);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic signed [FREQ_W-1:0] FREQ_MIN = FREQ_W'(4);

  // Generator.
  localparam logic [31:0] RNG_MULT = 32'd16807;

  typedef logic signed [LEVEL_WIDTH-1:0] level_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_PERIOD,
    ST_CHECK,
    ST_SCALE,
    ST_VALUE,
    ST_T_START,
    ST_DIV_T,
    ST_SQUARE,
    ST_FOURTH,
    ST_FIFTH,
    ST_FADE,
    ST_LIN,
    ST_SMO,
    ST_FINISH,
    ST_DONE
  } isn_state_e;

  // Divider request and status.
  typedef struct packed {
    logic                  start;
    logic [DIV_ITER_W-1:0] iters;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Rounds p / 2^sh to nearest, halves toward plus infinity.
  function automatic logic signed [PROD_W-1:0] round_shift(
    input logic signed [PROD_W-1:0] p,
    input int unsigned              sh
  );
    logic signed [PROD_W-1:0] bias;
    bias = PROD_W'(1) << (sh - 1);
    return (p + bias) >>> sh;
  endfunction

  // Clamps a widened level to the signed level range.
  function automatic level_t sat_level(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] lvl_max;
    logic signed [SUM_W-1:0] lvl_min;
    lvl_max = SUM_W'((64'sd1 <<< (LEVEL_WIDTH - 1)) - 64'sd1);
    lvl_min = SUM_W'(-(64'sd1 <<< (LEVEL_WIDTH - 1)));
    if (v > lvl_max) begin
      return lvl_max[LEVEL_WIDTH-1:0];
    end else if (v < lvl_min) begin
      return lvl_min[LEVEL_WIDTH-1:0];
    end
    return v[LEVEL_WIDTH-1:0];
  endfunction

endpackage

/* rtl/core/interpolated_sample_hold_noise_core.sv */
// Interpolated sample-and-hold noise core: one tick in, three levels out.
// Uses isn_pkg, isn_divider and isn_multiplier.
//
// Usage:
//   The input channel carries one audio sample tick (reset_level, frequency)
//   per request; the output channel returns one request holding the held,
//   linearly blended and fade-curve blended levels for that tick.
//   Registers (sample_rate, amplitude, offset, pattern) sit on the APB port
//   at byte addresses 0, 4, 8 and 12; the user must write them only while
//   the core is idle, which the core does not enforce. Each tick runs
//   through one shared restoring divider and one shared multiplier under a
//   sequencer. The divider finds the hold period and then the fraction t
//   (skipped when the period is zero or the count has reached it); the
//   multiplier advances the generator when the period has run out and forms
//   the fade curve and blends. A new input is accepted once the result is
//   in the output register; in_ready_o is high only in the idle state.
//   A finished result waits in the output register while the next tick is
//   accepted; if it is still not taken when the next result is done, the
//   sequencer holds in its last step until the receiver takes it.
//   Reset loads the register defaults and clears the generator, counter and
//   levels; outputs are not valid after reset.
module interpolated_sample_hold_noise_core import isn_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Tick input channel.
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     reset_level_i,
  input  logic signed [FREQ_W-1:0] frequency_i,
  // Level output channel.
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output level_t                   held_value_o,
  output level_t                   linear_value_o,
  output level_t                   smooth_value_o,
  // Configuration port.
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready
);

  isn_state_e state_q, state_d;

  // Configuration registers.
  logic [RATE_W-1:0]           sample_rate_q;
  logic signed [AMP_W-1:0]     amplitude_q;
  level_t                      offset_q;
  logic signed [PATTERN_W-1:0] pattern_q;

  // Persistent generator state.
  logic [31:0]            rng_q;
  logic                   last_reset_q;
  logic [COUNT_WIDTH-1:0] count_q;
  level_t                 newest_q, previous_q;

  // Per-tick working registers.
  logic [COUNT_WIDTH-1:0] period_q;
  logic [T_W-1:0]         t_q, t2_q, t5_q, s_q;
  level_t                 lin_q, smo_q;

  // Output register.
  logic   out_valid_q;
  level_t held_out_q, lin_out_q, smo_out_q;

  // Shared units.
  div_req_t                 div_req;
  div_stat_t                div_stat;
  logic [DIV_W-1:0]         div_rem_init, div_divisor;
  logic [DIV_NUM_W-1:0]     div_num, div_quot;
  logic                     mul_en;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;

  logic                     in_fire, cfg_write, out_load;
  logic                     fire;
  logic [DIV_W-1:0]         freq_clamped;
  logic [COUNT_WIDTH-1:0]   period_sat;
  logic [31:0]              rng_nz, rng_mult;
  logic signed [31:0]       rng_centered;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] rs16, rs31;
  logic [S_W-1:0]           s_sum;
  logic [S_W-1:0]           s_clamped;
  logic [REG_W-1:0]         reg_sel;

  isn_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .rem_init_i (div_rem_init),
    .num_i      (div_num),
    .divisor_i  (div_divisor),
    .stat_o     (div_stat),
    .quot_o     (div_quot)
  );

  isn_multiplier u_multiplier (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Handshakes.
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  assign reg_sel    = paddr[ADDR_W-1:2];
  assign cfg_write  = psel && penable && pwrite && pready;
  assign pready     = 1'b1;

  // Shared arithmetic around the units.
  always_comb begin
    freq_clamped = (frequency_i < FREQ_MIN) ? DIV_W'(FREQ_MIN) : DIV_W'(frequency_i);
    period_sat   = (32'(div_quot) > 32'(COUNT_MAX)) ? COUNT_MAX
                                                    : COUNT_WIDTH'(div_quot);
    fire         = count_q >= period_q;
    rng_nz       = (rng_q == 32'd0) ? 32'd1 : rng_q;
    rng_mult     = RNG_MULT + 32'(pattern_q);
    rng_centered = $signed({~prod[31], prod[30:0]});
    diff         = DIFF_W'(newest_q) - DIFF_W'(previous_q);
    rs16         = round_shift(prod, 16);
    rs31         = round_shift(prod, 31);
    s_sum        = FADE_GAIN * S_W'(rs16[T_W-1:0]) + S_W'(t5_q);
    s_clamped    = (s_sum > S_W'(ONE_Q16)) ? S_W'(ONE_Q16) : s_sum;
  end

  // Sequencer: next state and unit controls.
  always_comb begin
    state_d      = state_q;
    div_req      = '0;
    div_rem_init = '0;
    div_num      = '0;
    div_divisor  = '0;
    mul_en       = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    case (state_q)
      ST_IDLE: begin
        div_rem_init = '0;
        div_num      = {sample_rate_q, {FREQ_FRAC_W{1'b0}}};
        div_divisor  = freq_clamped;
        div_req.iters = PERIOD_ITERS;
        if (in_fire) begin
          div_req.start = 1'b1;
          state_d       = ST_DIV_PERIOD;
        end
      end
      ST_DIV_PERIOD: begin
        if (div_stat.done) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // Advance the generator only when the period has run out.
        if (fire) begin
          mul_en  = 1'b1;
          mul_a   = $signed(MUL_W'(rng_nz));
          mul_b   = $signed(MUL_W'(rng_mult));
          state_d = ST_SCALE;
        end else begin
          state_d = ST_T_START;
        end
      end
      ST_SCALE: begin
        mul_en  = 1'b1;
        mul_a   = MUL_W'(amplitude_q);
        mul_b   = MUL_W'(rng_centered);
        state_d = ST_VALUE;
      end
      ST_VALUE: begin
        state_d = ST_T_START;
      end
      ST_T_START: begin
        div_rem_init  = DIV_W'(count_q);
        div_num       = '0;
        div_divisor   = DIV_W'(period_q);
        div_req.iters = FRAC_ITERS;
        if (period_q == '0 || count_q == period_q) begin
          state_d = ST_SQUARE;
        end else begin
          div_req.start = 1'b1;
          state_d       = ST_DIV_T;
        end
      end
      ST_DIV_T: begin
        if (div_stat.done) begin
          state_d = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        mul_en  = 1'b1;
        mul_a   = $signed(MUL_W'(t_q));
        mul_b   = $signed(MUL_W'(t_q));
        state_d = ST_FOURTH;
      end
      ST_FOURTH: begin
        mul_en  = 1'b1;
        mul_a   = $signed(MUL_W'(rs16[T_W-1:0]));
        mul_b   = $signed(MUL_W'(rs16[T_W-1:0]));
        state_d = ST_FIFTH;
      end
      ST_FIFTH: begin
        mul_en  = 1'b1;
        mul_a   = $signed(MUL_W'(rs16[T_W-1:0]));
        mul_b   = $signed(MUL_W'(t_q));
        state_d = ST_FADE;
      end
      ST_FADE: begin
        mul_en  = 1'b1;
        mul_a   = $signed(MUL_W'(t2_q));
        mul_b   = $signed(MUL_W'(ONE_Q16 - t_q));
        state_d = ST_LIN;
      end
      ST_LIN: begin
        mul_en  = 1'b1;
        mul_a   = MUL_W'(diff);
        mul_b   = $signed(MUL_W'(t_q));
        state_d = ST_SMO;
      end
      ST_SMO: begin
        mul_en  = 1'b1;
        mul_a   = MUL_W'(diff);
        mul_b   = $signed(MUL_W'(s_q));
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Sequencer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_rate_q <= RESET_SAMPLE_RATE;
      amplitude_q   <= RESET_AMPLITUDE;
      offset_q      <= '0;
      pattern_q     <= '0;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_SAMPLE_RATE: sample_rate_q <= pwdata[RATE_W-1:0];
        REG_AMPLITUDE:   amplitude_q   <= pwdata[AMP_W-1:0];
        REG_OFFSET:      offset_q      <= pwdata[LEVEL_WIDTH-1:0];
        REG_PATTERN:     pattern_q     <= pwdata[PATTERN_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read back, signed registers sign-extended.
  always_comb begin
    case (reg_sel)
      REG_SAMPLE_RATE: prdata = DATA_W'(sample_rate_q);
      REG_AMPLITUDE:   prdata = DATA_W'(amplitude_q);
      REG_OFFSET:      prdata = DATA_W'(offset_q);
      REG_PATTERN:     prdata = DATA_W'(pattern_q);
      default:         prdata = '0;
    endcase
  end

  // Generator, counter and held levels.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rng_q        <= '0;
      last_reset_q <= 1'b0;
      count_q      <= '0;
      newest_q     <= '0;
      previous_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            // A rising reset level reseeds the generator.
            if (!last_reset_q && reset_level_i) begin
              rng_q <= 32'd1;
            end
            last_reset_q <= reset_level_i;
          end
        end
        ST_CHECK: begin
          if (!fire) begin
            count_q <= count_q + COUNT_WIDTH'(1);
          end
        end
        ST_SCALE: begin
          rng_q <= prod[31:0];
        end
        ST_VALUE: begin
          previous_q <= newest_q;
          newest_q   <= sat_level(rs31[SUM_W-1:0] + SUM_W'(offset_q));
          count_q    <= '0;
        end
        default: ;
      endcase
    end
  end

  // Per-tick working registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_DIV_PERIOD: begin
        if (div_stat.done) begin
          period_q <= period_sat;
        end
      end
      ST_T_START: begin
        if (period_q == '0) begin
          t_q <= '0;
        end else if (count_q == period_q) begin
          t_q <= ONE_Q16;
        end
      end
      ST_DIV_T: begin
        if (div_stat.done) begin
          t_q <= {1'b0, div_quot[FRAC_W-1:0]};
        end
      end
      ST_FOURTH: t2_q  <= rs16[T_W-1:0];
      ST_FADE:   t5_q  <= rs16[T_W-1:0];
      ST_LIN:    s_q   <= s_clamped[T_W-1:0];
      ST_SMO:    lin_q <= sat_level(SUM_W'(previous_q) + rs16[SUM_W-1:0]);
      ST_FINISH: smo_q <= sat_level(SUM_W'(previous_q) + rs16[SUM_W-1:0]);
      default: ;
    endcase
  end

  // Output request register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      held_out_q <= newest_q;
      lin_out_q  <= lin_q;
      smo_out_q  <= smo_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign held_value_o   = held_out_q;
  assign linear_value_o = lin_out_q;
  assign smooth_value_o = smo_out_q;

endmodule

/* rtl/core/isn_divider.sv */
// Restoring divider for the noise core, one quotient bit per cycle.
// Serves both the hold period and the fraction t. Depends on isn_pkg.
module isn_divider import isn_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  div_req_t             req_i,
  input  logic [DIV_W-1:0]     rem_init_i,
  input  logic [DIV_NUM_W-1:0] num_i,
  input  logic [DIV_W-1:0]     divisor_i,
  output div_stat_t            stat_o,
  output logic [DIV_NUM_W-1:0] quot_o
);

  logic                  busy_q, done_q;
  logic [DIV_ITER_W-1:0] cnt_q;
  logic [DIV_W-1:0]      rem_q, div_q;
  logic [DIV_NUM_W-1:0]  num_q, quot_q;

  logic [DIV_W:0]        trial;
  logic [DIV_W:0]        diff;
  logic                  take;

  // One trial subtraction per cycle; the remainder stays below the divisor.
  always_comb begin
    trial = {rem_q, num_q[DIV_NUM_W-1]};
    diff  = trial - {1'b0, div_q};
    take  = trial >= {1'b0, div_q};
  end

  // Iteration control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.iters;
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_ITER_W'(1);
        if (cnt_q == DIV_ITER_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand and quotient registers.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= rem_init_i;
      num_q  <= num_i;
      div_q  <= divisor_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= take ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      num_q  <= {num_q[DIV_NUM_W-2:0], 1'b0};
      quot_q <= {quot_q[DIV_NUM_W-2:0], take};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;

endmodule

/* rtl/core/isn_multiplier.sv */
// Shared signed multiplier of the noise core with a registered product.
// Every multiplication of the sequence goes through it. Depends on isn_pkg.
module isn_multiplier import isn_pkg::*; (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [MUL_W-1:0]  a_i,
  input  logic signed [MUL_W-1:0]  b_i,
  output logic signed [PROD_W-1:0] prod_o
);

  logic signed [PROD_W-1:0] prod_q;

  // Product is held until the next launch.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule

/* rtl/core/isn_checker.sv */
// Port-level checker for the noise core, bound to the top level.
// Depends on isn_pkg and interpolated_sample_hold_noise_core.
module isn_checker import isn_pkg::*; (
  input logic   clk_i,
  input logic   rst_ni,
  input logic   in_valid_i,
  input logic   in_ready_o,
  input logic   out_valid_o,
  input logic   out_ready_i,
  input level_t held_value_o,
  input level_t linear_value_o,
  input level_t smooth_value_o,
  input logic   pready
);

  // A stalled result request holds its levels.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(held_value_o)
      && $stable(linear_value_o) && $stable(smooth_value_o))
    else $error("stalled result request changed");

  // The core works on one tick at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while a tick is in progress");

  // A result is never produced in the cycle right after an accept.
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared too early");

  // A new result comes with the core back at idle.
  a_idle_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result delivered while not idle");

  // The configuration port never stalls.
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

endmodule

bind interpolated_sample_hold_noise_core isn_checker u_isn_checker (.*);
